// ===== rtl/jsms_pkg.sv =====
// ----------------------------------------------------------------------------
// jsms_pkg
// Shared types, codes and character constants for the JSON string map
// serializer.
// ----------------------------------------------------------------------------
package jsms_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned LenW     = 3;
  localparam int unsigned IdxW     = 3;

  typedef enum logic [2:0] {
    OP_CONTENT = 3'd0,
    OP_KEY     = 3'd1,
    OP_VALUE   = 3'd2,
    OP_END_STR = 3'd3,
    OP_END_MAP = 3'd4
  } op_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LBRACE    = 8'h7b;
  localparam logic [7:0] CH_RBRACE    = 8'h7d;
  localparam logic [7:0] CH_COMMA     = 8'h2c;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_LOW_A     = 8'h61;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6e;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7e;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } esc_rec_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_LOW_A + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

  function automatic esc_rec_t escape_byte(input logic [7:0] c);
    esc_rec_t   r;
    logic [7:0] letter;
    r      = '0;
    letter = 8'd0;
    unique case (c)
      CH_QUOTE:     letter = CH_QUOTE;
      CH_BACKSLASH: letter = CH_BACKSLASH;
      CH_BS:        letter = CH_LOW_B;
      CH_FF:        letter = CH_LOW_F;
      CH_LF:        letter = CH_LOW_N;
      CH_CR:        letter = CH_LOW_R;
      CH_TAB:       letter = CH_LOW_T;
      default:      letter = 8'd0;
    endcase
    if (letter != 8'd0) begin
      r.bytes[0] = CH_BACKSLASH;
      r.bytes[1] = letter;
      r.len      = 3'd2;
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      r.bytes[0] = c;
      r.len      = 3'd1;
    end else begin
      r.bytes[0] = CH_BACKSLASH;
      r.bytes[1] = CH_LOW_U;
      r.bytes[2] = CH_ZERO;
      r.bytes[3] = CH_ZERO;
      r.bytes[4] = hex_digit(c[7:4]);
      r.bytes[5] = hex_digit(c[3:0]);
      r.len      = 3'd6;
    end
    return r;
  endfunction

endpackage

// ===== rtl/json_string_map_serializer_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_map_serializer_unit
// Streaming JSON encoder for string-map tokens with string escaping.
// ----------------------------------------------------------------------------
// Tokens enter on the in_ stream: in_tuser carries the token kind (content
// byte, start key, start value, end string, end map) and in_tdata the raw
// byte. JSON text leaves on the out_ stream one byte per request, with
// out_tlast high on the final byte produced by a token. Unused token kinds
// are accepted and produce nothing.
// A token is classified in the cycle it is accepted and its byte run (one to
// six bytes) goes into a two-entry queue. The serializer drains the head run
// into the output register at one byte per cycle while out_tready is high;
// a token's first byte passes the queue entry and then the output register.
// One-byte tokens sustain one token per cycle while out_tready stays high;
// a token of n bytes takes n output bytes, and input stalls on a full queue.
// When the receiver drops out_tready the output byte holds, the queue fills
// and in_tready goes low. Reset empties the queue and the output register
// and clears the flag that records whether the current map holds a pair.
// ----------------------------------------------------------------------------
module json_string_map_serializer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [2:0] in_tuser,   // [2:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import jsms_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_not_empty;
  esc_rec_t q_push_rec;
  esc_rec_t q_head;

  jsms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_push_rec)
  );

  jsms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  jsms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== rtl/jsms_front.sv =====
// ----------------------------------------------------------------------------
// jsms_front
// Accepts tokens, builds the byte run of each one and tracks whether the
// current map already holds a pair.
// ----------------------------------------------------------------------------
module jsms_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic [2:0]         in_tuser,
  input  logic               q_full,
  output logic               q_push,
  output jsms_pkg::esc_rec_t q_rec
);
  import jsms_pkg::*;

  logic     pair_emitted_r;
  logic     pair_emitted_nxt;
  logic     accept;
  esc_rec_t rec;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    rec              = '0;
    pair_emitted_nxt = pair_emitted_r;
    unique case (op_t'(in_tuser))
      OP_CONTENT: begin
        rec = escape_byte(in_tdata);
      end
      OP_KEY: begin
        rec.bytes[0]     = pair_emitted_r ? CH_COMMA : CH_LBRACE;
        rec.bytes[1]     = CH_QUOTE;
        rec.len          = 3'd2;
        pair_emitted_nxt = 1'b1;
      end
      OP_VALUE: begin
        rec.bytes[0] = CH_COLON;
        rec.bytes[1] = CH_QUOTE;
        rec.len      = 3'd2;
      end
      OP_END_STR: begin
        rec.bytes[0] = CH_QUOTE;
        rec.len      = 3'd1;
      end
      OP_END_MAP: begin
        if (pair_emitted_r) begin
          rec.bytes[0] = CH_RBRACE;
          rec.len      = 3'd1;
        end else begin
          rec.bytes[0] = CH_LBRACE;
          rec.bytes[1] = CH_RBRACE;
          rec.len      = 3'd2;
        end
        pair_emitted_nxt = 1'b0;
      end
      default: begin
        rec = '0;
      end
    endcase
  end

  assign q_push = accept && (rec.len != '0);
  assign q_rec  = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_emitted_r <= 1'b0;
    end else if (accept) begin
      pair_emitted_r <= pair_emitted_nxt;
    end
  end

  a_end_map_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == OP_END_MAP) |=> !pair_emitted_r)
    else $error("pair flag not cleared after end of map");

endmodule

// ===== rtl/jsms_queue.sv =====
// ----------------------------------------------------------------------------
// jsms_queue
// Two-entry queue of byte runs between the token front end and the
// byte serializer.
// ----------------------------------------------------------------------------
module jsms_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsms_pkg::esc_rec_t push_rec,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output jsms_pkg::esc_rec_t head
);
  import jsms_pkg::*;

  esc_rec_t   mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

// ===== rtl/jsms_back.sv =====
// ----------------------------------------------------------------------------
// jsms_back
// Serializes the head byte run of the queue into the output register, one
// byte per cycle while out_tready allows, and marks the final byte of each run.
// ----------------------------------------------------------------------------
module jsms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  jsms_pkg::esc_rec_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import jsms_pkg::*;

  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] idx_nxt;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic            load;
  logic            is_last;

  assign load    = q_not_empty && (!out_valid_r || out_tready);
  assign is_last = (idx_r == q_head.len - 3'd1);
  assign q_pop   = load && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = is_last ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= q_head.bytes[idx_r];
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (idx_r < q_head.len))
    else $error("byte index beyond run length");

endmodule
